/* rtl/core/pfd_pkg.sv */
// Package for the Playfair digraph decrypt block.
// Types, constants and key-square helper functions; no dependencies.
package pfd_pkg;

  localparam int unsigned LetterW    = 8;
  localparam int unsigned SqDim      = 5;
  localparam int unsigned RowW       = SqDim * LetterW;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutDepth   = 2;

  localparam logic [LetterW-1:0] FillerX = 8'h58;

  localparam logic [1:0] WinEmpty = 2'd0;
  localparam logic [1:0] WinOne   = 2'd1;
  localparam logic [1:0] WinTwo   = 2'd2;

  typedef logic [SqDim-1:0][SqDim-1:0][LetterW-1:0] sq_t;

  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   row;
    logic [IdxW-1:0]   col;
  } loc_t;

  // one decrypted pair and/or end marker, handed from front to back
  typedef struct packed {
    logic [LetterW-1:0] p0;
    logic [LetterW-1:0] p1;
    logic               has_pair;
    logic               fin;
    logic               err;
  } entry_t;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               no_letter;
    logic               eom;
    logic               bad;
  } res_t;

  typedef enum logic [2:0] {
    PhP0    = 3'b001,
    PhP1    = 3'b010,
    PhFlush = 3'b100
  } phase_e;

  // first match in row-major order
  function automatic loc_t locate(sq_t sq, logic [LetterW-1:0] ch);
    loc_t l;
    l = '0;
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (sq[r][c] == ch) begin
          l.found = 1'b1;
          l.row   = IdxW'(r);
          l.col   = IdxW'(c);
        end
      end
    end
    return l;
  endfunction

  function automatic logic [IdxW-1:0] prev_idx(logic [IdxW-1:0] v);
    return (v == '0) ? IdxW'(SqDim - 1) : v - 1'b1;
  endfunction

endpackage

/* rtl/core/pfd_fifo.sv */
// Small register queue with push/pop and full/empty flags.
// Generic; no package dependency.
module pfd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/pfd_front.sv */
// Front end: key square registers, pair holder, letter lookup and decrypt.
// Depends on pfd_pkg.
module pfd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pfd_pkg::RowW-1:0]        cfg_wdata_i,
  input  logic                            accept_i,
  input  logic [pfd_pkg::LetterW-1:0]     letter_i,
  input  logic                            fin_i,
  output logic                            enq_o,
  output pfd_pkg::entry_t                 entry_o
);

  pfd_pkg::sq_t                    sq_q;
  logic [pfd_pkg::LetterW-1:0]     held_q, held_d;
  logic                            held_vld_q, held_vld_d;
  logic                            err_q, err_d;
  pfd_pkg::loc_t                   l1, l2;
  logic [pfd_pkg::LetterW-1:0]     d1, d2;
  logic                            pair_ok;

  assign l1 = pfd_pkg::locate(sq_q, held_q);
  assign l2 = pfd_pkg::locate(sq_q, letter_i);

  always_comb begin
    if (l1.row == l2.row) begin
      d1 = sq_q[l1.row][pfd_pkg::prev_idx(l1.col)];
      d2 = sq_q[l2.row][pfd_pkg::prev_idx(l2.col)];
    end else if (l1.col == l2.col) begin
      d1 = sq_q[pfd_pkg::prev_idx(l1.row)][l1.col];
      d2 = sq_q[pfd_pkg::prev_idx(l2.row)][l2.col];
    end else begin
      d1 = sq_q[l1.row][l2.col];
      d2 = sq_q[l2.row][l1.col];
    end
  end

  always_comb begin
    held_d     = held_q;
    held_vld_d = held_vld_q;
    err_d      = err_q;
    pair_ok    = 1'b0;
    if (!held_vld_q) begin
      if (fin_i) begin
        err_d = 1'b1;
      end else begin
        held_d     = letter_i;
        held_vld_d = 1'b1;
      end
    end else begin
      held_vld_d = 1'b0;
      if (l1.found && l2.found) begin
        pair_ok = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end
    if (fin_i) begin
      held_d     = '0;
      held_vld_d = 1'b0;
    end
  end

  assign enq_o            = accept_i && (pair_ok || fin_i);
  assign entry_o.p0       = d1;
  assign entry_o.p1       = d2;
  assign entry_o.has_pair = pair_ok;
  assign entry_o.fin      = fin_i;
  assign entry_o.err      = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q       <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < pfd_pkg::CfgIdxW'(pfd_pkg::SqDim))) begin
        sq_q[cfg_idx_i] <= cfg_wdata_i;
      end
      if (accept_i) begin
        held_q     <= held_d;
        held_vld_q <= held_vld_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

/* rtl/core/pfd_back.sv */
// Back end: plaintext window with filler-X removal and end-of-message flush.
// Depends on pfd_pkg.
module pfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfd_pkg::entry_t entry_i,
  input  logic            in_empty_i,
  output logic            in_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output pfd_pkg::res_t   res_o
);

  pfd_pkg::phase_e             phase_q, phase_d;
  logic [pfd_pkg::LetterW-1:0] w0_q, w0_d, w1_q, w1_d, ch;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        skip_q, skip_d;
  logic                        step;

  assign step = !in_empty_i && !out_full_i;
  assign ch   = (phase_q == pfd_pkg::PhP1) ? entry_i.p1 : entry_i.p0;

  always_comb begin
    phase_d    = phase_q;
    w0_d       = w0_q;
    w1_d       = w1_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    res_o      = '0;
    res_o.bad  = entry_i.err;
    if (step) begin
      case (phase_q)
        pfd_pkg::PhP0, pfd_pkg::PhP1: begin
          if (entry_i.has_pair) begin
            if (cnt_q == pfd_pkg::WinTwo) begin
              out_push_o   = 1'b1;
              res_o.letter = w0_q;
              if (skip_q && (w0_q == ch)) begin
                cnt_d  = pfd_pkg::WinOne;
                skip_d = 1'b0;
              end else begin
                w0_d   = w1_q;
                w1_d   = ch;
                skip_d = (ch == pfd_pkg::FillerX);
              end
            end else if (cnt_q == pfd_pkg::WinOne) begin
              w1_d   = ch;
              skip_d = (ch == pfd_pkg::FillerX);
              cnt_d  = pfd_pkg::WinTwo;
            end else begin
              w0_d   = ch;
              skip_d = 1'b0;
              cnt_d  = pfd_pkg::WinOne;
            end
          end
          if (phase_q == pfd_pkg::PhP0) begin
            phase_d = pfd_pkg::PhP1;
          end else if (entry_i.fin) begin
            phase_d = pfd_pkg::PhFlush;
          end else begin
            phase_d  = pfd_pkg::PhP0;
            in_pop_o = 1'b1;
          end
        end
        pfd_pkg::PhFlush: begin
          out_push_o = 1'b1;
          if (cnt_q == pfd_pkg::WinTwo) begin
            res_o.letter = w0_q;
            w0_d         = w1_q;
            cnt_d        = pfd_pkg::WinOne;
          end else begin
            res_o.eom = 1'b1;
            if (cnt_q == pfd_pkg::WinOne) begin
              res_o.letter = w0_q;
            end else begin
              res_o.no_letter = 1'b1;
            end
            w0_d     = '0;
            w1_d     = '0;
            cnt_d    = pfd_pkg::WinEmpty;
            skip_d   = 1'b0;
            phase_d  = pfd_pkg::PhP0;
            in_pop_o = 1'b1;
          end
        end
        default: begin
          phase_d = pfd_pkg::PhP0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pfd_pkg::PhP0;
      w0_q    <= '0;
      w1_q    <= '0;
      cnt_q   <= pfd_pkg::WinEmpty;
      skip_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      w0_q    <= w0_d;
      w1_q    <= w1_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

endmodule

/* rtl/core/playfair_digraph_decrypt.sv */
// Top level of the Playfair digraph decrypt block.
// Depends on pfd_pkg, pfd_front, pfd_fifo and pfd_back.
//
// Usage:
//   Ciphertext letters enter one item at a time through push/full; an item
//   is taken when push is high and full is low. Mark the last letter of a
//   message with final_letter_i. Results leave through empty/pop; the oldest
//   result sits on the result ports while empty is low.
//   The key square is loaded through cfg_we_i/cfg_idx_i/cfg_wdata_i, one
//   40-bit row per write, while the block is idle.
//   A letter's result passes the front decrypt into the pair queue and the
//   back window step into the output queue. Throughput: one letter per cycle
//   is sustained while the output queue has room; a final letter adds flush
//   steps, one per letter left in the window or one for an empty window.
//   The back end's window step sets this rate.
//   Reset clears the key square, the pair holder, the window and the error
//   flag. When the receiver stalls, the output queue fills, the back end
//   halts, the pair queue fills and full rises; nothing is lost.
module playfair_digraph_decrypt #(
  parameter int unsigned QueueDepth = pfd_pkg::QueueDepth,
  parameter int unsigned OutDepth   = pfd_pkg::OutDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pfd_pkg::RowW-1:0]      cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic [pfd_pkg::LetterW-1:0]   cipher_letter_i,
  input  logic                          final_letter_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [pfd_pkg::LetterW-1:0]   plain_letter_o,
  output logic                          no_letter_o,
  output logic                          end_of_message_o,
  output logic                          bad_input_o
);

  logic            accept, enq, q_empty, q_pop, out_full, out_push;
  pfd_pkg::entry_t entry_w, entry_r;
  pfd_pkg::res_t   res_w, res_r;

  assign accept = push && !full;

  pfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .letter_i    (cipher_letter_i),
    .fin_i       (final_letter_i),
    .enq_o       (enq),
    .entry_o     (entry_w)
  );

  pfd_fifo #(
    .Width ($bits(pfd_pkg::entry_t)),
    .Depth (QueueDepth)
  ) u_pair_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .wdata_i (entry_w),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (entry_r),
    .empty_o (q_empty)
  );

  pfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (entry_r),
    .in_empty_i (q_empty),
    .in_pop_o   (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .res_o      (res_w)
  );

  pfd_fifo #(
    .Width ($bits(pfd_pkg::res_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res_w),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_r),
    .empty_o (empty)
  );

  assign plain_letter_o   = res_r.letter;
  assign no_letter_o      = res_r.no_letter;
  assign end_of_message_o = res_r.eom;
  assign bad_input_o      = res_r.bad;

endmodule

/* verif/playfair_digraph_decrypt_tb.sv */
// Self-checking testbench for playfair_digraph_decrypt.
// Keeps its own model of the key square, pair holder and X-removal window and
// compares every result item; needs pfd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module playfair_digraph_decrypt_tb;
  import pfd_pkg::*;

  localparam int unsigned RegSquareRow0 = 0;
  localparam int unsigned NumCfgIdx     = 1 << CfgIdxW;
  localparam int unsigned NumCells      = SqDim * SqDim;

  typedef logic [LetterW-1:0] letters_t[$];

  typedef struct {
    logic [LetterW-1:0] letter;
    bit                 fin;
  } letter_item_t;

  typedef enum int {
    SqShuffled,
    SqShuffledBurst,
    SqRepeats,
    SqZeros,
    SqOnes,
    SqRandom,
    SqShuffledLate
  } square_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [RowW-1:0]      cfg_wdata_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [LetterW-1:0]   cipher_letter_i = '0;
  logic                 final_letter_i = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [LetterW-1:0]   plain_letter_o;
  logic                 no_letter_o;
  logic                 end_of_message_o;
  logic                 bad_input_o;

  playfair_digraph_decrypt dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .cipher_letter_i  (cipher_letter_i),
    .final_letter_i   (final_letter_i),
    .empty            (empty),
    .pop              (pop),
    .plain_letter_o   (plain_letter_o),
    .no_letter_o      (no_letter_o),
    .end_of_message_o (end_of_message_o),
    .bad_input_o      (bad_input_o)
  );

  always #5 clk_i = ~clk_i;

  // decryptor state
  logic [RowW-1:0]    key_rows [SqDim] = '{default: '0};
  logic [RowW-1:0]    staged_rows [SqDim] = '{default: '0};
  logic [LetterW-1:0] held_ch = '0;
  bit                 held_ok = 1'b0;
  logic [LetterW-1:0] win [2] = '{default: '0};
  int                 win_n = 0;
  bit                 drop_x = 1'b0;
  bit                 err_flag = 1'b0;
  letters_t           step_letters;

  res_t               plain_q[$];
  letter_item_t       cipher_q[$];
  letter_item_t       cur;
  bit                 no_idle = 1'b0;
  bit                 sending = 1'b0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  int                 popped = 0;
  int                 mismatch_cnt = 0;
  res_t               want;

  function automatic logic [LetterW-1:0] sq_cell(int r, int c);
    return key_rows[r % SqDim][LetterW * (c % SqDim) +: LetterW];
  endfunction

  // first match in row-major order
  function automatic bit find_letter(logic [LetterW-1:0] ch, output int r, output int c);
    for (int i = 0; i < SqDim; i++) begin
      for (int j = 0; j < SqDim; j++) begin
        if (sq_cell(i, j) == ch) begin
          r = i;
          c = j;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void window_push(logic [LetterW-1:0] ch);
    if (win_n >= 2) begin
      step_letters.push_back(win[0]);
      if (drop_x && win[0] == ch) begin
        win[0] = ch;
        win_n  = 1;
        drop_x = 1'b0;
      end else begin
        win[0] = win[1];
        win[1] = ch;
        drop_x = (ch == FillerX);
      end
    end else if (win_n == 1) begin
      win[1] = ch;
      drop_x = (ch == FillerX);
      win_n  = 2;
    end else begin
      win[0] = ch;
      drop_x = 1'b0;
      win_n  = 1;
    end
  endfunction

  function automatic void decrypt_letter(logic [LetterW-1:0] ch, bit fin);
    int   r1, c1, r2, c2;
    bit   ok1, ok2;
    res_t res;
    step_letters.delete();
    if (!held_ok) begin
      if (fin) begin
        err_flag = 1'b1;
      end else begin
        held_ch = ch;
        held_ok = 1'b1;
      end
    end else begin
      held_ok = 1'b0;
      ok1 = find_letter(held_ch, r1, c1);
      ok2 = find_letter(ch, r2, c2);
      if (!ok1 || !ok2) begin
        err_flag = 1'b1;
      end else if (r1 == r2) begin
        window_push(sq_cell(r1, c1 + SqDim - 1));
        window_push(sq_cell(r2, c2 + SqDim - 1));
      end else if (c1 == c2) begin
        window_push(sq_cell(r1 + SqDim - 1, c1));
        window_push(sq_cell(r2 + SqDim - 1, c2));
      end else begin
        window_push(sq_cell(r1, c2));
        window_push(sq_cell(r2, c1));
      end
    end
    if (fin) begin
      for (int i = 0; i < win_n; i++) step_letters.push_back(win[i]);
      held_ch = '0;
      held_ok = 1'b0;
      win[0]  = '0;
      win[1]  = '0;
      win_n   = 0;
      drop_x  = 1'b0;
    end
    foreach (step_letters[i]) begin
      res.letter    = step_letters[i];
      res.no_letter = 1'b0;
      res.eom       = fin && (i == step_letters.size() - 1);
      res.bad       = err_flag;
      plain_q.push_back(res);
    end
    if (fin && step_letters.size() == 0) begin
      res.letter    = '0;
      res.no_letter = 1'b1;
      res.eom       = 1'b1;
      res.bad       = err_flag;
      plain_q.push_back(res);
    end
  endfunction

  function automatic letters_t text(string s);
    letters_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic void queue_cipher(letters_t q);
    foreach (q[i]) cipher_q.push_back('{letter: q[i], fin: (i == q.size() - 1)});
  endfunction

  // encrypt an even-length plaintext with the current square
  function automatic void queue_plain_msg(letters_t plain);
    int                 r1, c1, r2, c2;
    logic [LetterW-1:0] e1, e2;
    for (int k = 0; k + 1 < plain.size(); k += 2) begin
      void'(find_letter(plain[k], r1, c1));
      void'(find_letter(plain[k+1], r2, c2));
      if (r1 == r2) begin
        e1 = sq_cell(r1, c1 + 1);
        e2 = sq_cell(r2, c2 + 1);
      end else if (c1 == c2) begin
        e1 = sq_cell(r1 + 1, c1);
        e2 = sq_cell(r2 + 1, c2);
      end else begin
        e1 = sq_cell(r1, c2);
        e2 = sq_cell(r2, c1);
      end
      cipher_q.push_back('{letter: e1, fin: 1'b0});
      cipher_q.push_back('{letter: e2, fin: (k + 2 >= plain.size())});
    end
  endfunction

  task automatic wait_idle();
    while (cipher_q.size() != 0 || sending || plain_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_square(bit poke_unused);
    int n;
    n = poke_unused ? NumCfgIdx : SqDim;
    for (int i = 0; i < n; i++) begin
      @(posedge clk_i);
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= CfgIdxW'(RegSquareRow0 + i);
      if (i < SqDim) begin
        cfg_wdata_i <= staged_rows[i];
        key_rows[i] = staged_rows[i];
      end else begin
        cfg_wdata_i <= {8'($urandom()), $urandom()};
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      sending  = 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        decrypt_letter(cipher_letter_i, final_letter_i);
        sending = 1'b0;
      end
      if (!sending) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (cipher_q.size() != 0) begin
          cur = cipher_q.pop_front();
          push            <= 1'b1;
          cipher_letter_i <= cur.letter;
          final_letter_i  <= cur.fin;
          sending  = 1'b1;
          gap_left = no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver and checker; long hold-off now and then so full gets exercised
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      popped     = 0;
    end else begin
      if (pop && !empty) begin
        if (plain_q.size() == 0) begin
          $error("unexpected item: plain_letter %h", plain_letter_o);
          mismatch_cnt++;
        end else begin
          want = plain_q.pop_front();
          if (!want.no_letter && plain_letter_o !== want.letter) begin
            $error("plain_letter: expected %h, actual %h", want.letter, plain_letter_o);
            mismatch_cnt++;
          end
          if (no_letter_o !== want.no_letter) begin
            $error("no_letter: expected %b, actual %b", want.no_letter, no_letter_o);
            mismatch_cnt++;
          end
          if (end_of_message_o !== want.eom) begin
            $error("end_of_message: expected %b, actual %b", want.eom, end_of_message_o);
            mismatch_cnt++;
          end
          if (bad_input_o !== want.bad) begin
            $error("bad_input: expected %b, actual %b", want.bad, bad_input_o);
            mismatch_cnt++;
          end
        end
        popped++;
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
        if (popped % 150 == 20) hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    letters_t           msg;
    logic [LetterW-1:0] alpha [NumCells];
    logic [LetterW-1:0] pick;
    logic [LetterW-1:0] cell_val;
    string              key_text;
    square_kind_e       kind;
    int                 len, r, c, n, j, items;
    key_text = "PLAYFIREXMBCDGHKNOQSTUVWZ";
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumCells; i++) begin
      staged_rows[i / SqDim][LetterW * (i % SqDim) +: LetterW] = key_text[i];
    end
    load_square(1'b0);

    // same-row and same-column wrap, rectangle, X removal, tail X, equal pair
    queue_cipher(text("PL"));
    queue_cipher(text("PI"));
    queue_plain_msg(text("HIDE"));
    queue_plain_msg(text("AXAB"));
    queue_plain_msg(text("AXAX"));
    queue_cipher(text("AA"));
    // absent letter, lone final letter, extreme codes absent from the square
    queue_cipher(text("JAPL"));
    queue_cipher(text("A"));
    msg.delete();
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    queue_cipher(msg);

    for (int p = 0; p <= SqShuffledLate; p++) begin
      kind = square_kind_e'(p);
      wait_idle();
      no_idle = (kind == SqShuffledBurst);
      case (kind)
        SqRepeats: begin
          for (int i = 0; i < NumCells; i++) begin
            cell_val = $urandom_range(0, 1) ? FillerX : 8'(8'h41 + $urandom_range(0, 2));
            staged_rows[i / SqDim][LetterW * (i % SqDim) +: LetterW] = cell_val;
          end
        end
        SqZeros: begin
          foreach (staged_rows[i]) staged_rows[i] = '0;
        end
        SqOnes: begin
          foreach (staged_rows[i]) staged_rows[i] = '1;
        end
        SqRandom: begin
          foreach (staged_rows[i]) staged_rows[i] = {8'($urandom()), $urandom()};
        end
        default: begin
          n = 0;
          for (int i = 0; i < 26; i++) begin
            if (8'(8'h41 + i) != 8'h4A) begin
              alpha[n] = 8'(8'h41 + i);
              n++;
            end
          end
          for (int i = NumCells - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            pick     = alpha[i];
            alpha[i] = alpha[j];
            alpha[j] = pick;
          end
          for (int i = 0; i < NumCells; i++) begin
            staged_rows[i / SqDim][LetterW * (i % SqDim) +: LetterW] = alpha[i];
          end
        end
      endcase
      load_square(kind == SqZeros);

      items = 0;
      while (items < 33) begin
        msg.delete();
        if ($urandom_range(0, 4) != 0) begin
          len = 2 * $urandom_range(1, 5);
          while (msg.size() < len) begin
            pick = sq_cell($urandom_range(0, SqDim - 1), $urandom_range(0, SqDim - 1));
            if ($urandom_range(0, 2) == 0 && find_letter(FillerX, r, c)) begin
              msg.push_back(pick);
              msg.push_back(FillerX);
              msg.push_back(pick);
            end else begin
              msg.push_back(pick);
            end
          end
          if (msg.size() % 2 != 0) begin
            msg.push_back(sq_cell($urandom_range(0, SqDim - 1), $urandom_range(0, SqDim - 1)));
          end
          queue_plain_msg(msg);
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            if ($urandom_range(0, 1) != 0) begin
              msg.push_back(sq_cell($urandom_range(0, SqDim - 1), $urandom_range(0, SqDim - 1)));
            end else begin
              msg.push_back(8'($urandom_range(0, 255)));
            end
          end
          queue_cipher(msg);
        end
        items += msg.size();
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && plain_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
